/* hw/rtl/qse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_pkg
// Shared constants and types of the sorting engine: capacity, data width and
// the control word that the top level broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package qse_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef struct packed {
		logic  ins;        // insert ins_value into the sorted row
		logic  shift;      // move every cell one place toward the head
		data_t ins_value;
	} cell_ctrl_t;

endpackage

/* hw/rtl/qse_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_cell
// One place of the sorted row. Holds a value and a valid flag; on insert it
// keeps its value, takes the new one or takes its lower neighbor's, and on
// shift it takes its upper neighbor's value.
// ----------------------------------------------------------------------------
module qse_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  qse_pkg::cell_ctrl_t ctrl,
	input  logic                prev_take,
	input  logic                prev_vld,
	input  qse_pkg::data_t      prev_value,
	input  qse_pkg::data_t      next_value,
	input  logic                next_vld,
	output qse_pkg::data_t      value_q,
	output logic                vld_q,
	output logic                take
);

	// of the empty cells only the first may take, so the valid cells stay a sorted prefix
	assign take = ctrl.ins && (vld_q ? (ctrl.ins_value < value_q) : prev_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= next_vld;
		end else if (take) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
		end else if (take) begin
			// lower neighbor also moves up: inherit its old value
			value_q <= prev_take ? prev_value : ctrl.ins_value;
		end
	end

endmodule

/* hw/rtl/qse_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_chain
// Row of MAX_ITEMS cells kept in ascending order. Cell 0 holds the smallest
// value and is the head that the drain reads.
// ----------------------------------------------------------------------------
module qse_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  qse_pkg::cell_ctrl_t ctrl,
	output qse_pkg::data_t      head_value,
	output logic                head_vld
);

	qse_pkg::data_t                    cell_value [qse_pkg::MAX_ITEMS];
	logic [qse_pkg::MAX_ITEMS-1:0]     cell_vld;
	logic [qse_pkg::MAX_ITEMS-1:0]     cell_take;

	for (genvar i = 0; i < qse_pkg::MAX_ITEMS; i++) begin : g_cell
		logic           prev_take;
		logic           prev_vld;
		qse_pkg::data_t prev_value;
		logic           next_vld;
		qse_pkg::data_t next_value;

		if (i == 0) begin : g_head
			assign prev_take  = 1'b0;
			assign prev_vld   = 1'b1;
			assign prev_value = '0;
		end else begin : g_body
			assign prev_take  = cell_take[i-1];
			assign prev_vld   = cell_vld[i-1];
			assign prev_value = cell_value[i-1];
		end

		if (i == qse_pkg::MAX_ITEMS - 1) begin : g_tail
			assign next_vld   = 1'b0;
			assign next_value = '0;
		end else begin : g_inner
			assign next_vld   = cell_vld[i+1];
			assign next_value = cell_value[i+1];
		end

		qse_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_take  (prev_take),
			.prev_vld   (prev_vld),
			.prev_value (prev_value),
			.next_value (next_value),
			.next_vld   (next_vld),
			.value_q    (cell_value[i]),
			.vld_q      (cell_vld[i]),
			.take       (cell_take[i])
		);
	end

	assign head_value = cell_value[0];
	assign head_vld   = cell_vld[0];

endmodule

/* hw/rtl/quicksort_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_engine_top
// Collects a run of signed values and returns them in ascending order.
//
// Input channel (value, is_last; in_valid/in_ready): one request per cycle
// while loading. Each value is inserted into a row of 64 sorting cells in
// the cycle it is accepted, so a run is already sorted when its last request
// arrives. Values beyond 64 are dropped and mark every result of the run.
// Output channel (sorted_value, last_out, overflowed; out_valid/out_ready):
// after the last request, in_ready drops and the row drains from its head,
// one result per cycle while out_ready is high. The last request moves the
// state register to the drain, and the head value then enters the output
// register when it is free; a run loads in full, then drains through the
// single head port of the cell row. in_ready returns once the final result
// sits in the output register, so the next run may start loading while that
// result waits. A stalled receiver holds the output register and halts the
// drain. Reset empties the row and clears the run state.
// ----------------------------------------------------------------------------
module quicksort_engine_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic signed [31:0]   value,
	input  logic                 is_last,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic signed [31:0]   sorted_value,
	output logic                 last_out,
	output logic                 overflowed,
	output logic                 out_valid,
	input  logic                 out_ready
);

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	qse_pkg::cnt_t       count_q;
	qse_pkg::cnt_t       remaining_q;
	logic                overflow_seen_q;
	logic                run_ovf_q;
	logic                out_valid_q;
	qse_pkg::data_t      out_value_q;
	logic                out_last_q;
	logic                out_ovf_q;

	qse_pkg::cell_ctrl_t ctrl;
	qse_pkg::data_t      head_value;
	logic                head_vld;

	logic                in_fire;
	logic                has_room;
	logic                store;
	logic                load_out;
	qse_pkg::cnt_t       run_count;

	assign in_ready  = (state_q == ST_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign has_room  = (count_q < qse_pkg::CNT_W'(qse_pkg::MAX_ITEMS));
	assign store     = in_fire && has_room;
	assign load_out  = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);
	assign run_count = store ? (count_q + qse_pkg::CNT_W'(1)) : count_q;

	always_comb begin
		ctrl.ins       = store;
		ctrl.shift     = load_out;
		ctrl.ins_value = value;
	end

	qse_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.head_value (head_value),
		.head_vld   (head_vld)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			count_q         <= '0;
			remaining_q     <= '0;
			overflow_seen_q <= 1'b0;
			run_ovf_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			out_last_q      <= 1'b0;
			out_ovf_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_fire) begin
						if (is_last) begin
							// close the run: hand count and flag to the drain
							remaining_q     <= run_count;
							run_ovf_q       <= overflow_seen_q || !has_room;
							count_q         <= '0;
							overflow_seen_q <= 1'b0;
							if (run_count != '0) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							count_q <= run_count;
							if (!has_room) begin
								overflow_seen_q <= 1'b1;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_last_q  <= (remaining_q == qse_pkg::CNT_W'(1));
						out_ovf_q   <= run_ovf_q;
						remaining_q <= remaining_q - qse_pkg::CNT_W'(1);
						if (remaining_q == qse_pkg::CNT_W'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= head_value;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign last_out     = out_last_q;
	assign overflowed   = out_ovf_q;

	// the row must have a value ready for every pending result
	a_head_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> head_vld)
		else $error("cell row empty while results are pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qse_pkg::CNT_W'(qse_pkg::MAX_ITEMS))
		else $error("element count beyond capacity");

	a_drain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (remaining_q != '0))
		else $error("drain running with nothing left");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (remaining_q == qse_pkg::CNT_W'(1))) |=>
			(out_last_q && (state_q == ST_LOAD)))
		else $error("final result not marked or drain not closed");

	a_no_shift_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.shift))
		else $error("insert and shift in the same cycle");

endmodule

/* test/tb_quicksort_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quicksort_engine_top
// Self-checking bench for the sorting engine. Runs of signed values are fed
// through the request channel; a predictor keeps each run in sorted order,
// caps it at the capacity and tracks dropped values, then queues the
// expected results. The monitor checks every result, field by field, in
// order. Both sides idle at random, and the receiver stalls once for a long
// stretch so that the engine fills and holds off its input.
// ----------------------------------------------------------------------------
module tb_quicksort_engine_top;

	typedef struct {
		qse_pkg::data_t value;
		logic           is_last;
	} run_item_t;

	typedef struct {
		qse_pkg::data_t value;
		logic           last;
		logic           ovf;
	} sorted_result_t;

	localparam qse_pkg::data_t VAL_MIN = 32'sh8000_0000;
	localparam qse_pkg::data_t VAL_MAX = 32'sh7fff_ffff;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	qse_pkg::data_t value = '0;
	logic           is_last = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	qse_pkg::data_t sorted_value;
	logic           last_out;
	logic           overflowed;
	logic           out_valid;
	logic           out_ready = 1'b0;

	run_item_t      pending_items[$];
	qse_pkg::data_t held_sorted[$];
	logic           run_dropped = 1'b0;
	sorted_result_t sorted_expect[$];

	int items_accepted = 0;
	int results_checked = 0;
	int runs_closed = 0;
	int overflow_runs = 0;
	int error_count = 0;
	logic rx_hold = 1'b0;

	quicksort_engine_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.is_last      (is_last),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflowed   (overflowed),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

	always #4 clk = ~clk;

	function automatic logic quiet_phase();
		return items_accepted >= 150 && items_accepted < 220;
	endfunction

	// Keep the held run in ascending order as values arrive; drop past capacity.
	function automatic void absorb_request(run_item_t it);
		int pos;
		sorted_result_t r;
		if (held_sorted.size() < qse_pkg::MAX_ITEMS) begin
			pos = held_sorted.size();
			while (pos > 0 && held_sorted[pos-1] > it.value)
				pos--;
			held_sorted.insert(pos, it.value);
		end else begin
			run_dropped = 1'b1;
		end
		if (it.is_last) begin
			for (int k = 0; k < held_sorted.size(); k++) begin
				r.value = held_sorted[k];
				r.last  = (k == held_sorted.size() - 1);
				r.ovf   = run_dropped;
				sorted_expect.push_back(r);
			end
			runs_closed++;
			if (run_dropped)
				overflow_runs++;
			held_sorted.delete();
			run_dropped = 1'b0;
		end
	endfunction

	function automatic qse_pkg::data_t pick_value();
		qse_pkg::data_t corner[4];
		corner[0] = VAL_MIN;
		corner[1] = VAL_MAX;
		corner[2] = '0;
		corner[3] = -1;
		case ($urandom_range(3))
			0: return qse_pkg::data_t'($signed($urandom_range(8)) - 4);
			1: return corner[$urandom_range(3)];
			default: return qse_pkg::data_t'($urandom);
		endcase
	endfunction

	task automatic queue_request(qse_pkg::data_t v, logic last);
		run_item_t it;
		it.value   = v;
		it.is_last = last;
		pending_items.push_back(it);
	endtask

	task automatic queue_random_run(int len);
		for (int k = 0; k < len; k++)
			queue_request(pick_value(), k == len - 1);
	endtask

	// Request driver: hold a request until accepted, then offer the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				absorb_request(pending_items.pop_front());
				items_accepted <= items_accepted + 1;
			end
			if (pending_items.size() > 0 && (quiet_phase() || $urandom_range(99) >= 15)) begin
				value    <= pending_items[0].value;
				is_last  <= pending_items[0].is_last;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		sorted_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (sorted_expect.size() == 0) begin
					$display("%0t: unexpected result value %0d last %0b ovf %0b",
						$time, sorted_value, last_out, overflowed);
					error_count++;
				end else begin
					e = sorted_expect.pop_front();
					if (sorted_value !== e.value) begin
						$display("%0t: result %0d sorted_value expected %0d actual %0d",
							$time, results_checked, e.value, sorted_value);
						error_count++;
					end
					if (last_out !== e.last) begin
						$display("%0t: result %0d last_out expected %0b actual %0b",
							$time, results_checked, e.last, last_out);
						error_count++;
					end
					if (overflowed !== e.ovf) begin
						$display("%0t: result %0d overflowed expected %0b actual %0b",
							$time, results_checked, e.ovf, overflowed);
						error_count++;
					end
				end
				results_checked++;
			end
			out_ready <= !rx_hold && (quiet_phase() || $urandom_range(99) >= 15);
		end
	end

	// Long receiver stall so the engine fills and drops in_ready.
	initial begin
		while (items_accepted < 40)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#400us;
		$display("timeout: %0d results still expected", sorted_expect.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		int rand_items;
		int len;

		// single-value runs at both extremes
		queue_request(VAL_MAX, 1'b1);
		queue_request(VAL_MIN, 1'b1);
		// mixed extremes, neighbors of the extremes and duplicates
		queue_request(0, 1'b0);
		queue_request(-1, 1'b0);
		queue_request(VAL_MAX, 1'b0);
		queue_request(VAL_MIN, 1'b0);
		queue_request(1, 1'b0);
		queue_request(5, 1'b0);
		queue_request(5, 1'b0);
		queue_request(-5, 1'b0);
		queue_request(VAL_MIN + 1, 1'b0);
		queue_request(VAL_MAX - 1, 1'b1);
		// descending, ascending and all-equal runs
		queue_request(3, 1'b0);
		queue_request(2, 1'b0);
		queue_request(1, 1'b1);
		queue_request(-2, 1'b0);
		queue_request(-1, 1'b0);
		queue_request(0, 1'b0);
		queue_request(1, 1'b1);
		queue_request(7, 1'b0);
		queue_request(7, 1'b0);
		queue_request(7, 1'b1);

		// exactly full, then overfull with the last three values dropped
		queue_random_run(qse_pkg::MAX_ITEMS);
		queue_random_run(qse_pkg::MAX_ITEMS + 3);
		rand_items = pending_items.size();
		while (rand_items < 250) begin
			if ($urandom_range(14) == 0)
				len = $urandom_range(qse_pkg::MAX_ITEMS + 6, qse_pkg::MAX_ITEMS - 2);
			else
				len = $urandom_range(12, 1);
			queue_random_run(len);
			rand_items += len;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid || sorted_expect.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d requests in %0d runs (%0d overfull), %0d results checked",
			items_accepted, runs_closed, overflow_runs, results_checked);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", error_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
